// ===== rtl/swerve_wheel_kinematics_core_defines.svh =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics assertion macros
// Concurrent check wrappers that drop out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SWERVE_WHEEL_KINEMATICS_CORE_DEFINES_SVH
`define SWERVE_WHEEL_KINEMATICS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define SWK_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swk check failed");
// Invariant checked at every clock edge outside reset.
`define SWK_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("swk check failed");
`else
`define SWK_ASSERT_IMP(name, ante, cons)
`define SWK_ASSERT_ALWAYS(name, expr)
`endif

`endif

// ===== rtl/swk_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics package
// Widths, constants, shared types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swk_pkg;

	localparam int CORDIC_STAGES = 16;

	// port field widths
	localparam int SPD_W      = 14;
	localparam int IDX_W      = 2;
	localparam int ANG_W      = 12;
	localparam int WSPD_W     = 16;
	localparam int RPM_W      = 8;
	localparam int WB_W       = 12;
	localparam int TRK_W      = 12;
	localparam int RAD_W      = 10;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	// wheel vector components, scaled by 2000
	localparam int XW   = 27;
	localparam int AW   = 26;
	localparam int SQ_W = 2 * AW;
	localparam logic signed [XW-1:0] CMD_SCALE = XW'(2000);

	// square root: one result bit per stage
	localparam int SQW      = 54;
	localparam int SQ_STEPS = 27;
	localparam int RT_W     = 27;

	// CORDIC datapath
	localparam int CW     = 29;
	localparam int ZW     = 23;
	localparam int ATAN_W = 21;

	// root / 2000 = (root >> 4) / 125 by reciprocal, exact for 23-bit operands
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] DIV125_K = 24'd8589935;
	localparam int Q_W = 47;

	// angle conversion, 2^-20 rad to mrad
	localparam int ZP_W = 32;
	localparam logic [9:0] MRAD_SCALE = 10'd1000;
	localparam int MRAD_SHIFT = 20;
	localparam logic [ANG_W-1:0] MRAD_MAX = 12'd1571;

	// rpm = speed * 60 * 2^16 / (411775 * radius)
	localparam int NUM_W = 38;
	localparam int DEN_W = 29;
	localparam int REM_W = 39;
	localparam logic [21:0] RPM_SCALE   = 22'd3932160;
	localparam logic [18:0] TWO_PI_Q16  = 19'd411775;

	localparam logic [IDX_W-1:0] IDX_LAST4 = 2'd3;
	localparam logic [IDX_W-1:0] IDX_LAST2 = 2'd1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEER_MODE,
		REG_WHEELBASE,
		REG_TRACK,
		REG_RADIUS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_XZERO,
		CLS_YZERO,
		CLS_OBLIQUE
	} wheel_cls_t;

	typedef struct packed {
		logic             steer_mode;
		logic [WB_W-1:0]  wheelbase_mm;
		logic [TRK_W-1:0] track_mm;
		logic [RAD_W-1:0] wheel_radius_mm;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]     idx;
		logic                 last;
		wheel_cls_t           cls;
		logic                 yaw_pos;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} wheel_job_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		wheel_cls_t       cls;
		logic             yaw_pos;
		logic             flip;
	} wheel_meta_t;

	typedef struct packed {
		wheel_meta_t       meta;
		logic [WSPD_W-1:0] spd;
		logic [ANG_W-1:0]  ang;
	} wheel_res_t;

	// atan(2^-i) in units of 2^-20 rad
	function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned i);
		logic [ATAN_W-1:0] v;
		case (i)
			0: v = 21'd823550;
			1: v = 21'd486170;
			2: v = 21'd256879;
			3: v = 21'd130396;
			4: v = 21'd65451;
			5: v = 21'd32757;
			6: v = 21'd16383;
			7: v = 21'd8192;
			8: v = 21'd4096;
			9: v = 21'd2048;
			10: v = 21'd1024;
			11: v = 21'd512;
			12: v = 21'd256;
			13: v = 21'd128;
			14: v = 21'd64;
			15: v = 21'd32;
			16: v = 21'd16;
			17: v = 21'd8;
			18: v = 21'd4;
			19: v = 21'd2;
			20: v = 21'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/swk_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Swerve command channel
// Body velocity command word with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swk_cmd_if import swk_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [SPD_W-1:0] forward_speed;
	logic signed [SPD_W-1:0] lateral_speed;
	logic signed [SPD_W-1:0] yaw_rate;

	modport source(output valid, output forward_speed, output lateral_speed,
		output yaw_rate, input ready);
	modport sink(input valid, input forward_speed, input lateral_speed,
		input yaw_rate, output ready);
endinterface

`default_nettype wire

// ===== rtl/swk_res_if.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel result channel
// Per-wheel steering angle, speed and rpm word with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swk_res_if import swk_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         wheel_index;
	logic signed [ANG_W-1:0]  steer_angle;
	logic [WSPD_W-1:0]        wheel_speed;
	logic [RPM_W-1:0]         wheel_rpm;
	logic                     oblique;
	logic                     last_wheel;

	modport source(output valid, output wheel_index, output steer_angle,
		output wheel_speed, output wheel_rpm, output oblique, output last_wheel,
		input ready);
	modport sink(input valid, input wheel_index, input steer_angle,
		input wheel_speed, input wheel_rpm, input oblique, input last_wheel,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/swk_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Swerve configuration write channel
// Register index and write data word with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swk_cfg_if import swk_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/swerve_wheel_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics core
// Body velocity command in, one steering angle / speed / rpm word per wheel out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : one word per body command (forward, lateral mm/s; yaw mrad/s).
//   res  : four words per command in four-wheel mode, two in two-wheel mode,
//          in wheel order; last_wheel marks the final word of a command.
//   cfg  : register writes (steer mode, wheelbase, track, wheel radius),
//          always ready; write only while no command is in flight.
// Throughput: one result word per cycle while res is ready; the front end
//   issues one wheel per cycle while the job queue has room.
// Pipeline: after its command is accepted, each wheel word passes the
//   27-stage square root, the rpm divider and the scaling stages around them.
// Reset: registers go to mode 0, wheelbase 500, track 400, radius 50; all
//   pipeline valid bits clear.
// Back-pressure: a stalled res freezes the wheel pipeline; the 4-entry job
//   queue then fills and cmd.ready drops until words drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "swerve_wheel_kinematics_core_defines.svh"

module swerve_wheel_kinematics_core import swk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	swk_cfg_if.sink   cfg,
	swk_cmd_if.sink   cmd,
	swk_res_if.source res
);

	cfg_t             cfg_q;
	// rpm divisor, 2*pi (Q16) times wheel radius; tracks radius register
	logic [DEN_W-1:0] den_q;

	logic             job_valid_f;
	logic             job_ready_f;
	wheel_job_t       job_f;
	logic             job_valid_b;
	logic             job_ready_b;
	wheel_job_t       job_b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_mode      <= 1'b0;
			cfg_q.wheelbase_mm    <= WB_W'(500);
			cfg_q.track_mm        <= TRK_W'(400);
			cfg_q.wheel_radius_mm <= RAD_W'(50);
			den_q                 <= DEN_W'(TWO_PI_Q16) * DEN_W'(50);
		end else begin
			den_q <= DEN_W'(TWO_PI_Q16) * DEN_W'(cfg_q.wheel_radius_mm);
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_STEER_MODE: cfg_q.steer_mode      <= cfg.data[0];
					REG_WHEELBASE:  cfg_q.wheelbase_mm    <= cfg.data[WB_W-1:0];
					REG_TRACK:      cfg_q.track_mm        <= cfg.data[TRK_W-1:0];
					REG_RADIUS:     cfg_q.wheel_radius_mm <= cfg.data[RAD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// front: command capture and per-wheel vector issue
	swk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.job_valid (job_valid_f),
		.job_ready (job_ready_f),
		.job       (job_f)
	);

	// decouples issue from the wheel pipeline stall
	swk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid_f),
		.in_ready  (job_ready_f),
		.in_data   (job_f),
		.out_valid (job_valid_b),
		.out_ready (job_ready_b),
		.out_data  (job_b)
	);

	// back: root, angle, speed and rpm per wheel
	swk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.den       (den_q),
		.job_valid (job_valid_b),
		.job_ready (job_ready_b),
		.job       (job_b),
		.res       (res)
	);

	// angle always inside +/- pi/2
	`SWK_ASSERT_IMP(a_angle_range, res.valid, ($signed(res.steer_angle) <= 12'sd1571) && ($signed(res.steer_angle) >= -12'sd1571))
	// last word lands on the final wheel of the configured mode
	`SWK_ASSERT_IMP(a_last_index, res.valid && res.last_wheel, res.wheel_index == (cfg_q.steer_mode ? IDX_LAST2 : IDX_LAST4))
	// standing wheel never turns
	`SWK_ASSERT_IMP(a_zero_rpm, res.valid && (res.wheel_speed == '0), res.wheel_rpm == '0)
	// axis-aligned vectors steer to zero or a right angle only
	`SWK_ASSERT_IMP(a_axis_angle, res.valid && !res.oblique, (res.steer_angle == '0) || ($signed(res.steer_angle) == 12'sd1571) || ($signed(res.steer_angle) == -12'sd1571))

endmodule

`default_nettype wire

// ===== rtl/swk_queue.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel job queue
// Small register FIFO between the command front end and the wheel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swk_queue import swk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  wheel_job_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output wheel_job_t out_data
);

	wheel_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push;
	logic                pop;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/swk_front.sv =====
// ----------------------------------------------------------------------------
// Swerve command front end
// Takes a body command, forms each wheel vector and classifies it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swk_front import swk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	swk_cmd_if.sink    cmd,
	output logic       job_valid,
	input  logic       job_ready,
	output wheel_job_t job
);

	logic                 hold_q;
	logic                 two_q;
	logic                 yaw_pos_q;
	logic [IDX_W-1:0]     idx_q;
	logic signed [XW-1:0] fwd2k_q;
	logic signed [XW-1:0] lat2k_q;
	logic signed [XW-1:0] tw_q;
	logic signed [XW-1:0] bw_q;

	logic signed [XW-1:0] fwd_x;
	logic signed [XW-1:0] lat_x;
	logic signed [XW-1:0] yaw_x;
	logic signed [XW-1:0] wx;
	logic signed [XW-1:0] wy;
	logic                 last_w;
	logic                 issue;
	logic                 accept;

	assign fwd_x = XW'(cmd.forward_speed);
	assign lat_x = XW'(cmd.lateral_speed);
	assign yaw_x = XW'(cmd.yaw_rate);

	assign last_w     = two_q ? (idx_q == IDX_LAST2) : (idx_q == IDX_LAST4);
	assign issue      = hold_q && job_ready;
	assign cmd.ready  = !hold_q || (job_ready && last_w);
	assign accept     = cmd.valid && cmd.ready;
	assign job_valid  = hold_q;

	always_comb begin
		wx = fwd2k_q;
		if (!two_q) begin
			wx = idx_q[1] ? (fwd2k_q + tw_q) : (fwd2k_q - tw_q);
		end
		wy = (idx_q == 2'd0 || idx_q == 2'd3) ? (lat2k_q + bw_q) : (lat2k_q - bw_q);
		job.idx     = idx_q;
		job.last    = last_w;
		job.yaw_pos = yaw_pos_q;
		job.x       = wx;
		job.y       = wy;
		if (wx == '0 && wy == '0) begin
			job.cls = CLS_ZERO;
		end else if (wx == '0) begin
			job.cls = CLS_XZERO;
		end else if (wy == '0) begin
			job.cls = CLS_YZERO;
		end else begin
			job.cls = CLS_OBLIQUE;
		end
	end

	// command payload, loaded on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd2k_q   <= fwd_x * CMD_SCALE;
			lat2k_q   <= lat_x * CMD_SCALE;
			tw_q      <= yaw_x * $signed(XW'(cfg.track_mm));
			bw_q      <= yaw_x * $signed(XW'(cfg.wheelbase_mm));
			yaw_pos_q <= !cmd.yaw_rate[SPD_W-1] && (cmd.yaw_rate != '0);
			two_q     <= cfg.steer_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (accept) begin
				hold_q <= 1'b1;
				idx_q  <= '0;
			end else if (issue) begin
				if (last_w) begin
					hold_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/swk_back.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel pipeline: square root, CORDIC angle, speed scaling, rpm divide.
// One wheel a cycle while res is ready; a stalled res freezes every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swk_back import swk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEN_W-1:0] den,
	input  logic             job_valid,
	output logic             job_ready,
	input  wheel_job_t       job,
	swk_res_if.source        res
);

	localparam int NDIV = RPM_W;

	logic en;

	// stage 1: magnitudes and squares
	logic                 vld_s1;
	wheel_meta_t          meta_s1;
	logic [AW-1:0]        ax_s1;
	logic [AW-1:0]        ay_s1;
	logic [SQ_W-1:0]      sqx_s1;
	logic [SQ_W-1:0]      sqy_s1;
	logic [AW-1:0]        ax;
	logic [AW-1:0]        ay;
	wheel_meta_t          meta_in;

	// root and CORDIC stages, index 0 is the load stage
	logic                 vld_sq  [0:SQ_STEPS];
	wheel_meta_t          meta_sq [0:SQ_STEPS];
	logic [SQW-1:0]       n_sq    [0:SQ_STEPS];
	logic [SQW-1:0]       r_sq    [0:SQ_STEPS];
	logic signed [CW-1:0] cx_sq   [0:SQ_STEPS];
	logic signed [CW-1:0] cy_sq   [0:SQ_STEPS];
	logic signed [ZW-1:0] cz_sq   [0:SQ_STEPS];

	// scaling stages
	logic                 vld_s4;
	wheel_meta_t          meta_s4;
	logic [Q_W-1:0]       qprod_s4;
	logic [ZP_W-1:0]      zprod_s4;
	logic [ZW-2:0]        zc;

	logic                 vld_s5;
	wheel_res_t           res_s5;
	logic [Q_W-RECIP_SHIFT-1:0] qv;
	logic [ZP_W-1:0]      mr;
	logic [ZP_W-MRAD_SHIFT-1:0] mraw;
	logic [ANG_W-1:0]     mag;
	logic [ANG_W-1:0]     ang;

	logic                 vld_s6;
	wheel_res_t           res_s6;
	logic [NUM_W-1:0]     num_s6;

	// rpm divide stages
	logic                 vld_dv [0:NDIV];
	wheel_res_t           res_dv [0:NDIV];
	logic [REM_W-1:0]     rem_dv [0:NDIV];
	logic [RPM_W-1:0]     quo_dv [0:NDIV];
	logic                 sat_dv [0:NDIV];

	logic                 res_vld_q;
	wheel_res_t           res_q;
	logic [RPM_W-1:0]     rpm_q;

	assign en        = !res_vld_q || res.ready;
	assign job_ready = en;

	assign ax = job.x[XW-1] ? AW'(-job.x) : AW'(job.x);
	assign ay = job.y[XW-1] ? AW'(-job.y) : AW'(job.y);

	always_comb begin
		meta_in.idx     = job.idx;
		meta_in.last    = job.last;
		meta_in.cls     = job.cls;
		meta_in.yaw_pos = job.yaw_pos;
		meta_in.flip    = job.x[XW-1] ^ job.y[XW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_in;
			ax_s1   <= ax;
			ay_s1   <= ay;
			sqx_s1  <= ax * ax;
			sqy_s1  <= ay * ay;

			meta_sq[0] <= meta_s1;
			n_sq[0]    <= SQW'(sqx_s1) + SQW'(sqy_s1);
			r_sq[0]    <= '0;
			cx_sq[0]   <= CW'(ax_s1);
			cy_sq[0]   <= CW'(ay_s1);
			cz_sq[0]   <= '0;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQW-1:0] trial;

		assign trial = r_sq[k] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				meta_sq[k+1] <= meta_sq[k];
				if (n_sq[k] >= trial) begin
					n_sq[k+1] <= n_sq[k] - trial;
					r_sq[k+1] <= (r_sq[k] >> 1) + BIT;
				end else begin
					n_sq[k+1] <= n_sq[k];
					r_sq[k+1] <= r_sq[k] >> 1;
				end
			end
		end

		if (k < CORDIC_STAGES) begin : g_rot
			logic signed [ZW-1:0] da;
			assign da = $signed(ZW'(atan_entry(k)));
			always_ff @(posedge clk) begin
				if (en) begin
					if (!cy_sq[k][CW-1]) begin
						cx_sq[k+1] <= cx_sq[k] + (cy_sq[k] >>> k);
						cy_sq[k+1] <= cy_sq[k] - (cx_sq[k] >>> k);
						cz_sq[k+1] <= cz_sq[k] + da;
					end else begin
						cx_sq[k+1] <= cx_sq[k] - (cy_sq[k] >>> k);
						cy_sq[k+1] <= cy_sq[k] + (cx_sq[k] >>> k);
						cz_sq[k+1] <= cz_sq[k] - da;
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					cx_sq[k+1] <= cx_sq[k];
					cy_sq[k+1] <= cy_sq[k];
					cz_sq[k+1] <= cz_sq[k];
				end
			end
		end
	end

	// negative accumulated angle clamps to zero
	assign zc = cz_sq[SQ_STEPS][ZW-1] ? '0 : cz_sq[SQ_STEPS][ZW-2:0];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4  <= meta_sq[SQ_STEPS];
			qprod_s4 <= Q_W'(r_sq[SQ_STEPS][RT_W-1:4]) * Q_W'(DIV125_K);
			zprod_s4 <= ZP_W'(zc) * ZP_W'(MRAD_SCALE);
		end
	end

	assign qv   = qprod_s4[Q_W-1:RECIP_SHIFT];
	assign mr   = zprod_s4 + (ZP_W'(1) << (MRAD_SHIFT - 1));
	assign mraw = mr[ZP_W-1:MRAD_SHIFT];
	assign mag  = (mraw > ANG_W'(MRAD_MAX)) ? MRAD_MAX : ANG_W'(mraw);

	always_comb begin
		case (meta_s4.cls)
			CLS_XZERO:   ang = meta_s4.yaw_pos ? MRAD_MAX : ANG_W'(-MRAD_MAX);
			CLS_OBLIQUE: ang = meta_s4.flip ? ANG_W'(-mag) : mag;
			default:     ang = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.meta <= meta_s4;
			res_s5.spd  <= qv[Q_W-RECIP_SHIFT-1] ? '1 : WSPD_W'(qv);
			res_s5.ang  <= ang;

			res_s6 <= res_s5;
			num_s6 <= NUM_W'(res_s5.spd) * NUM_W'(RPM_SCALE);

			res_dv[0] <= res_s6;
			rem_dv[0] <= REM_W'(num_s6);
			quo_dv[0] <= '0;
			sat_dv[0] <= (num_s6 != '0) && (REM_W'(num_s6) >= (REM_W'(den) << RPM_W));
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		localparam int B = NDIV - 1 - k;
		logic [REM_W-1:0] dsh;
		logic             take;

		assign dsh  = REM_W'(den) << B;
		assign take = !sat_dv[k] && (rem_dv[k] != '0) && (rem_dv[k] >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				res_dv[k+1] <= res_dv[k];
				sat_dv[k+1] <= sat_dv[k];
				rem_dv[k+1] <= take ? (rem_dv[k] - dsh) : rem_dv[k];
				quo_dv[k+1] <= quo_dv[k] | (take ? (RPM_W'(1) << B) : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_dv[NDIV];
			rpm_q <= sat_dv[NDIV] ? '1 : quo_dv[NDIV];
		end
	end

	// valid bits of every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			res_vld_q <= 1'b0;
			for (int i = 0; i <= SQ_STEPS; i++) begin
				vld_sq[i] <= 1'b0;
			end
			for (int i = 0; i <= NDIV; i++) begin
				vld_dv[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= job_valid;
			vld_sq[0] <= vld_s1;
			for (int i = 1; i <= SQ_STEPS; i++) begin
				vld_sq[i] <= vld_sq[i-1];
			end
			vld_s4    <= vld_sq[SQ_STEPS];
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_dv[0] <= vld_s6;
			for (int i = 1; i <= NDIV; i++) begin
				vld_dv[i] <= vld_dv[i-1];
			end
			res_vld_q <= vld_dv[NDIV];
		end
	end

	assign res.valid       = res_vld_q;
	assign res.wheel_index = res_q.meta.idx;
	assign res.steer_angle = res_q.ang;
	assign res.wheel_speed = res_q.spd;
	assign res.wheel_rpm   = rpm_q;
	assign res.oblique     = (res_q.meta.cls == CLS_OBLIQUE);
	assign res.last_wheel  = res_q.meta.last;

endmodule

`default_nettype wire

// ===== dv/swerve_wheel_kinematics_core_tb.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics core testbench
// Drives body commands through several register settings and idle patterns,
// predicts or types in every wheel word and checks each one as it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swerve_wheel_kinematics_core_tb import swk_pkg::*;;

	// one expected wheel word
	typedef struct {
		logic [IDX_W-1:0]        idx;
		logic signed [ANG_W-1:0] ang;
		logic [WSPD_W-1:0]       spd;
		logic [RPM_W-1:0]        rpm;
		logic                    obl;
		logic                    last;
	} wheel_word_t;

	// directed row: command plus an optional typed-in answer for every wheel
	typedef struct {
		int                      fwd;
		int                      lat;
		int                      yaw;
		bit                      typed;
		logic signed [ANG_W-1:0] ang;
		logic [WSPD_W-1:0]       spd;
		logic [RPM_W-1:0]        rpm;
		logic                    obl;
	} cmd_row_t;

	localparam int DRAIN_CYCLES = 60;   // slack past the pipeline depth
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off

	// atan(2^-i), 2^-20 rad units
	localparam longint ATAN_LUT [24] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swk_cfg_if cfg ();
	swk_cmd_if cmd ();
	swk_res_if res ();

	swerve_wheel_kinematics_core uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.cmd   (cmd),
		.res   (res)
	);

	always #5 clk = ~clk;

	// bench copy of the registers
	logic             mode_q;
	logic [WB_W-1:0]  wbase_q;
	logic [TRK_W-1:0] track_q;
	logic [RAD_W-1:0] radius_q;

	wheel_word_t wheel_q[$];   // wheel words still owed by the block
	int errors = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_cnt = 0;

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cmd.valid = 1'b0;
		cmd.forward_speed = '0;
		cmd.lateral_speed = '0;
		cmd.yaw_rate = '0;
		res.ready = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring CORDIC on the first quadrant, result in mrad
	function automatic longint steer_mrad(input longint ax, input longint ay);
		longint x, y, z, xo, m;
		x = ax;
		y = ay;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			xo = x;
			if (y >= 0) begin
				x += y >>> i;
				y -= xo >>> i;
				z += ATAN_LUT[i];
			end else begin
				x -= y >>> i;
				y += xo >>> i;
				z -= ATAN_LUT[i];
			end
		end
		if (z < 0)
			z = 0;
		m = (z * 1000 + (64'sd1 <<< 19)) >>> 20;
		return (m > 1571) ? 1571 : m;
	endfunction

	// works out every wheel word one command causes
	task automatic predict_wheels(input int fwd, input int lat, input int yaw);
		longint tw, bw, wx, wy, ax, ay, ang;
		longint unsigned spd, rpm;
		int n, sx, sy;
		wheel_word_t w;
		tw = longint'(track_q) * yaw;
		bw = longint'(wbase_q) * yaw;
		n = mode_q ? 2 : 4;
		for (int k = 0; k < n; k++) begin
			if (n == 4) begin
				sx = (k < 2) ? 1 : -1;
				sy = (k == 0 || k == 3) ? 1 : -1;
			end else begin
				sx = 0;
				sy = (k == 0) ? 1 : -1;
			end
			wx = 2000 * longint'(fwd) - sx * tw;
			wy = 2000 * longint'(lat) + sy * bw;
			ax = (wx < 0) ? -wx : wx;
			ay = (wy < 0) ? -wy : wy;
			spd = int_sqrt(ax * ax + ay * ay) / 2000;
			if (spd > 65535)
				spd = 65535;
			ang = 0;
			if (wx == 0 && wy != 0) begin
				ang = (yaw > 0) ? 1571 : -1571;
			end else if (wx != 0 && wy != 0) begin
				ang = steer_mrad(ax, ay);
				if ((wx < 0) != (wy < 0))
					ang = -ang;
			end
			if (radius_q == 0)
				rpm = (spd != 0) ? 255 : 0;
			else
				rpm = (spd * 3932160) / (64'd411775 * radius_q);
			if (rpm > 255)
				rpm = 255;
			w.idx = k[IDX_W-1:0];
			w.ang = ang[ANG_W-1:0];
			w.spd = spd[WSPD_W-1:0];
			w.rpm = rpm[RPM_W-1:0];
			w.obl = (wx != 0 && wy != 0);
			w.last = (k == n - 1);
			wheel_q.push_back(w);
		end
	endtask

	// register write; bench copy tracks it at the handshake
	task automatic write_reg(input cfg_reg_t r, input int val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data <= val[CFG_DATA_W-1:0];
		forever begin
			@(negedge clk);
			if (cfg.ready) break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (r)
			REG_STEER_MODE: mode_q = val[0];
			REG_WHEELBASE:  wbase_q = val[WB_W-1:0];
			REG_TRACK:      track_q = val[TRK_W-1:0];
			REG_RADIUS:     radius_q = val[RAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input int m, input int wb, input int tr, input int rad);
		write_reg(REG_STEER_MODE, m);
		write_reg(REG_WHEELBASE, wb);
		write_reg(REG_TRACK, tr);
		write_reg(REG_RADIUS, rad);
	endtask

	// offers one command word; valid stays up afterwards for back-to-back words
	task automatic send_cmd(input int fwd, input int lat, input int yaw,
			input bit pred);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(posedge clk);
			cmd.valid <= 1'b0;
		end
		@(posedge clk);
		cmd.valid <= 1'b1;
		cmd.forward_speed <= fwd[SPD_W-1:0];
		cmd.lateral_speed <= lat[SPD_W-1:0];
		cmd.yaw_rate <= yaw[SPD_W-1:0];
		forever begin
			@(negedge clk);
			if (cmd.ready) break;
			@(posedge clk);
		end
		// accepted at the coming edge
		if (pred)
			predict_wheels($signed(fwd[SPD_W-1:0]), $signed(lat[SPD_W-1:0]),
				$signed(yaw[SPD_W-1:0]));
	endtask

	// sender pause until everything owed has come back, plus pipeline slack
	task automatic drain_all();
		@(posedge clk);
		cmd.valid <= 1'b0;
		while (wheel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int rand_speed();
		case ($urandom_range(9))
			0:       return 0;
			1:       return $urandom_range(16383) - 8192;   // raw 14-bit pattern
			2, 3:    return $urandom_range(400) - 200;
			default: return $urandom_range(16000) - 8000;
		endcase
	endfunction

	// receiver: ready pattern, with a long counted hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			res.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_done != hold_reqs) begin
			res.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end else begin
			res.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// checker: a word with both valid and ready at negedge is taken at the next edge
	always @(negedge clk) begin
		wheel_word_t w;
		if (arst_n && res.valid && res.ready) begin
			if (wheel_q.size() == 0) begin
				$error("unexpected wheel word idx=%0d", res.wheel_index);
				errors++;
			end else begin
				w = wheel_q.pop_front();
				if (res.wheel_index !== w.idx) begin
					$error("wheel_index exp %0d got %0d", w.idx, res.wheel_index);
					errors++;
				end
				if (res.steer_angle !== w.ang) begin
					$error("steer_angle exp %0d got %0d", w.ang, res.steer_angle);
					errors++;
				end
				if (res.wheel_speed !== w.spd) begin
					$error("wheel_speed exp %0d got %0d", w.spd, res.wheel_speed);
					errors++;
				end
				if (res.wheel_rpm !== w.rpm) begin
					$error("wheel_rpm exp %0d got %0d", w.rpm, res.wheel_rpm);
					errors++;
				end
				if (res.oblique !== w.obl) begin
					$error("oblique exp %0d got %0d", w.obl, res.oblique);
					errors++;
				end
				if (res.last_wheel !== w.last) begin
					$error("last_wheel exp %0d got %0d", w.last, res.last_wheel);
					errors++;
				end
			end
		end
	end

	// directed commands, run on reset register values
	cmd_row_t dir_rows[] = '{
		// all components zero
		'{0, 0, 0, 1, 12'sd0, 16'd0, 8'd0, 1'b0},
		// lateral zero: angle 0, speed |x|
		'{1000, 0, 0, 1, 12'sd0, 16'd1000, 8'd190, 1'b0},
		'{-1000, 0, 0, 1, 12'sd0, 16'd1000, 8'd190, 1'b0},
		// forward zero with no yaw: -pi/2
		'{0, 1000, 0, 1, -12'sd1571, 16'd1000, 8'd190, 1'b0},
		'{0, -1000, 0, 1, -12'sd1571, 16'd1000, 8'd190, 1'b0},
		'{8000, 8000, 8000, 0, 0, 0, 0, 0},
		'{-8000, -8000, -8000, 0, 0, 0, 0, 0},
		'{8000, -8000, 8000, 0, 0, 0, 0, 0},
		'{-8000, 8000, -8000, 0, 0, 0, 0, 0},
		'{8191, 8191, 8191, 0, 0, 0, 0, 0},
		'{-8192, -8192, -8192, 0, 0, 0, 0, 0},
		'{0, 0, 1000, 0, 0, 0, 0, 0},
		'{0, 0, -1000, 0, 0, 0, 0, 0},
		// forward zero at wheels 0/1 with positive yaw: +pi/2
		'{400, 0, 2000, 0, 0, 0, 0, 0},
		'{-400, 0, -2000, 0, 0, 0, 0, 0},
		// lateral zero at some wheels
		'{0, 500, 2000, 0, 0, 0, 0, 0},
		'{1, 1, 0, 0, 0, 0, 0, 0},
		'{1, -1, 0, 0, 0, 0, 0, 0},
		'{5000, 1, 0, 0, 0, 0, 0, 0},
		'{1, 5000, 0, 0, 0, 0, 0, 0},
		'{3000, 3000, 0, 0, 0, 0, 0, 0}
	};

	initial begin
		int n_rand;
		mode_q = 1'b0;
		wbase_q = 12'd500;
		track_q = 12'd400;
		radius_q = 10'd50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part on reset values, no idling
		foreach (dir_rows[i]) begin
			send_cmd(dir_rows[i].fwd, dir_rows[i].lat, dir_rows[i].yaw,
				!dir_rows[i].typed);
			if (dir_rows[i].typed)
				for (int k = 0; k < 4; k++)
					wheel_q.push_back('{k[IDX_W-1:0], dir_rows[i].ang,
						dir_rows[i].spd, dir_rows[i].rpm, dir_rows[i].obl, k == 3});
		end
		drain_all();

		// random phases: registers and idle pattern change between them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0; rx_stall_pct = 0;
				end
				1: begin
					load_regs(1, 4000, 4000, 1000);
					tx_idle_pct = 46; rx_stall_pct = 0;
				end
				2: begin
					load_regs(0, 1, 1, 10);
					tx_idle_pct = 0; rx_stall_pct = 46;
				end
				3: begin
					// out-of-range values, taken as raw bits
					load_regs(1, 4095, 0, 0);
					tx_idle_pct = 30; rx_stall_pct = 30;
				end
				4: begin
					load_regs(0, 4095, 4095, 1023);
					tx_idle_pct = 0; rx_stall_pct = 0;
					hold_reqs++;
				end
				default: begin
					load_regs($urandom_range(1), $urandom_range(4000, 1),
						$urandom_range(4000, 1), $urandom_range(1000, 10));
					tx_idle_pct = 30; rx_stall_pct = 30;
				end
			endcase
			n_rand = 67;
			for (int i = 0; i < n_rand; i++)
				send_cmd(rand_speed(), rand_speed(),
					($urandom_range(5) == 0) ? 0 : rand_speed(), 1'b1);
			drain_all();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
